/* sv/hmtq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the heightmap height query block.
// Depends on nothing; every other file of the block imports it.
package hmtq_pkg;

	localparam int MAP_DIM_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OUT_DEPTH     = 16;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] REG_CELL_SIZE     = 2'd0;
	localparam logic [1:0] REG_HEIGHT_SCALE  = 2'd1;
	localparam logic [1:0] REG_HEIGHT_OFFSET = 2'd2;
	localparam logic [1:0] REG_MAP_SIZE      = 2'd3;

	typedef struct packed {
		logic [30:0]        cell_size;
		logic [30:0]        height_scale;
		logic signed [31:0] height_offset;
		logic [8:0]         map_size;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] new_y;
		logic               outside;
		logic               lifted;
	} res_t;

	// Width of one classified word between the front and the back.
	function automatic int entry_bits(input int map_dim, input int frac_bits);
		return 58 + 2 * $clog2(map_dim) + 2 * frac_bits;
	endfunction

endpackage

/* sv/hmtq_front.sv */
`timescale 1ns / 1ps
// Front end: input register, two pipelined restoring dividers and cell classification.
// Depends on hmtq_pkg.
module hmtq_front #(
	parameter int MAP_DIM   = hmtq_pkg::MAP_DIM_DEF,
	parameter int FRAC_BITS = hmtq_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                kind,
	input  logic [7:0]          row,
	input  logic [7:0]          col,
	input  logic [7:0]          sample,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  hmtq_pkg::cfg_t      cfg,
	output logic                out_valid,
	output logic [hmtq_pkg::entry_bits(MAP_DIM, FRAC_BITS)-1:0] out_entry
);
	import hmtq_pkg::*;

	localparam int DW  = 31 + FRAC_BITS;
	localparam int IW  = $clog2(MAP_DIM);
	localparam int EFW = $clog2(MAP_DIM + 1);

	typedef struct packed {
		logic                 kind;
		logic [7:0]           row;
		logic [7:0]           col;
		logic [7:0]           sample;
		logic signed [31:0]   y;
		logic                 outside;
		logic [IW-1:0]        gx;
		logic [IW-1:0]        gz;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fz;
	} entry_t;

	typedef struct packed {
		logic               kind;
		logic [7:0]         row;
		logic [7:0]         col;
		logic [7:0]         sample;
		logic signed [31:0] y;
		logic               early;
		logic [30:0]        ux;
		logic [30:0]        uz;
		logic [30:0]        rx;
		logic [30:0]        rz;
		logic [DW-1:0]      qx;
		logic [DW-1:0]      qz;
	} div_t;

	// One quotient bit: the top bit of the result is the bit, the rest the new remainder.
	function automatic logic [31:0] div_step(input logic [30:0] r, input logic b,
		input logic [30:0] d);
		logic [31:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			return {1'b1, 31'(t - {1'b0, d})};
		end
		return {1'b0, t[30:0]};
	endfunction

	div_t          dv_sn [DW+1];
	logic [DW:0]   vld_sn;
	logic [EFW-1:0] eff;
	logic          out_valid_q;
	entry_t        out_entry_q;
	entry_t        ent;
	logic [30:0]   gxw;
	logic [30:0]   gzw;
	logic [30:0]   lim;

	assign eff = (32'(cfg.map_size) > 32'(MAP_DIM)) ? EFW'(MAP_DIM) : EFW'(cfg.map_size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_sn      <= {vld_sn[DW-1:0], in_valid};
			out_valid_q <= vld_sn[DW];
		end
	end

	always_ff @(posedge clk) begin
		dv_sn[0].kind   <= kind;
		dv_sn[0].row    <= row;
		dv_sn[0].col    <= col;
		dv_sn[0].sample <= sample;
		dv_sn[0].y      <= pos_y;
		dv_sn[0].early  <= pos_x[31] | pos_z[31] | (cfg.cell_size == '0) | (eff < EFW'(2));
		dv_sn[0].ux     <= pos_x[30:0];
		dv_sn[0].uz     <= pos_z[30:0];
		dv_sn[0].rx     <= '0;
		dv_sn[0].rz     <= '0;
		dv_sn[0].qx     <= '0;
		dv_sn[0].qz     <= '0;
	end

	// Dividend is the position shifted up by FRAC_BITS; one quotient bit per stage.
	for (genvar k = 0; k < DW; k++) begin : g_div
		logic        bx;
		logic        bz;
		logic [31:0] sx;
		logic [31:0] sz;
		div_t        nx;
		if (k < 31) begin : g_in
			assign bx = dv_sn[k].ux[30-k];
			assign bz = dv_sn[k].uz[30-k];
		end else begin : g_zero
			assign bx = 1'b0;
			assign bz = 1'b0;
		end
		assign sx = div_step(dv_sn[k].rx, bx, cfg.cell_size);
		assign sz = div_step(dv_sn[k].rz, bz, cfg.cell_size);
		always_comb begin
			nx    = dv_sn[k];
			nx.rx = sx[30:0];
			nx.rz = sz[30:0];
			nx.qx = {dv_sn[k].qx[DW-2:0], sx[31]};
			nx.qz = {dv_sn[k].qz[DW-2:0], sz[31]};
		end
		always_ff @(posedge clk) begin
			dv_sn[k+1] <= nx;
		end
	end

	assign gxw = dv_sn[DW].qx[DW-1:FRAC_BITS];
	assign gzw = dv_sn[DW].qz[DW-1:FRAC_BITS];
	assign lim = 31'(eff) - 31'd1;

	always_comb begin
		ent.kind    = dv_sn[DW].kind;
		ent.row     = dv_sn[DW].row;
		ent.col     = dv_sn[DW].col;
		ent.sample  = dv_sn[DW].sample;
		ent.y       = dv_sn[DW].y;
		ent.outside = dv_sn[DW].early | (gxw >= lim) | (gzw >= lim);
		ent.gx      = gxw[IW-1:0];
		ent.gz      = gzw[IW-1:0];
		ent.fx      = dv_sn[DW].qx[FRAC_BITS-1:0];
		ent.fz      = dv_sn[DW].qz[FRAC_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		out_entry_q <= ent;
	end

	assign out_valid = out_valid_q;
	assign out_entry = out_entry_q;

endmodule

/* sv/hmtq_queue.sv */
`timescale 1ns / 1ps
// Queue between front and back: a memory FIFO whose read data is registered.
// Depends on hmtq_pkg for the house conventions only.
module hmtq_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         nonempty,
	output logic         rvalid,
	output logic [W-1:0] rdata
);
	import hmtq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          rvalid_q;
	logic [W-1:0]  rdata_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			rp_q     <= '0;
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + 1'b1;
			end
			cnt_q    <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			rvalid_q <= pop;
		end
	end

	assign nonempty = (cnt_q != '0);
	assign rvalid   = rvalid_q;
	assign rdata    = rdata_q;

endmodule

/* sv/hmtq_back.sv */
`timescale 1ns / 1ps
// Back end: four parity banks of the height store, blend, scale, offset and ground clamp.
// Depends on hmtq_pkg.
module hmtq_back #(
	parameter int MAP_DIM   = hmtq_pkg::MAP_DIM_DEF,
	parameter int FRAC_BITS = hmtq_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [hmtq_pkg::entry_bits(MAP_DIM, FRAC_BITS)-1:0] in_entry,
	input  hmtq_pkg::cfg_t cfg,
	output logic           load_done,
	output logic           res_valid,
	output hmtq_pkg::res_t res
);
	import hmtq_pkg::*;

	localparam int IW   = $clog2(MAP_DIM);
	localparam int HALF = (MAP_DIM + 1) / 2;
	localparam int BD   = HALF * HALF;
	localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
	localparam int ONE  = 1 << FRAC_BITS;
	localparam int FW   = FRAC_BITS + 1;

	typedef struct packed {
		logic                 kind;
		logic [7:0]           row;
		logic [7:0]           col;
		logic [7:0]           sample;
		logic signed [31:0]   y;
		logic                 outside;
		logic [IW-1:0]        gx;
		logic [IW-1:0]        gz;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fz;
	} entry_t;

	// Samples are split over four banks by the parity of row and column,
	// so the four corners of a cell always sit in four different banks.
	function automatic logic [AW-1:0] addr_of(input logic [IW:0] r, input logic [IW:0] c);
		return AW'(((32'(r) >> 1) * HALF) + (32'(c) >> 1));
	endfunction

	entry_t         e1;
	logic           we;
	logic [1:0]     wbank;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr [4];
	logic [7:0]     bank_mem [4][BD];

	logic [7:0]     smp_s2 [4];
	entry_t         e_s2;
	logic           v_s2;

	logic           gx0;
	logic           gz0;
	logic [7:0]     s00, s10, s01, s11;
	logic [FW-1:0]  fx1, fz1, fsum;
	logic [FW-1:0]  wa, wb, wc;
	logic [7:0]     sa, sb, sc;

	logic [FW-1:0]  wa_s3, wb_s3, wc_s3;
	logic [7:0]     sa_s3, sb_s3, sc_s3;
	logic           v_s3, v_s4, v_s5, v_s6, v_s7, rv_s8;
	logic signed [31:0] y_s3, y_s4, y_s5, y_s6, y_s7;
	logic           o_s3, o_s4, o_s5, o_s6, o_s7;

	logic [FRAC_BITS+9:0]  wsum;
	logic [FRAC_BITS+7:0]  w_s4;
	logic [FRAC_BITS+38:0] prod;
	logic [FRAC_BITS+38:0] p_s5;
	logic [38:0]    vq;
	logic [39:0]    ssum;
	logic [38:0]    vq_s6;
	logic [31:0]    q0_s6;
	logic [39:0]    rem;
	logic [31:0]    q_s7;
	logic signed [34:0] hw;
	logic signed [31:0] hsat;
	logic           lift;
	res_t           rnext;
	res_t           res_s8;

	assign e1        = entry_t'(in_entry);
	assign load_done = in_valid & (e1.kind == KIND_LOAD);

	always_comb begin
		logic px;
		logic pz;
		logic [IW:0] rr;
		logic [IW:0] cc;
		we    = load_done & (32'(e1.row) < 32'(MAP_DIM)) & (32'(e1.col) < 32'(MAP_DIM));
		wbank = {e1.row[0], e1.col[0]};
		waddr = addr_of((IW+1)'(e1.row), (IW+1)'(e1.col));
		for (int b = 0; b < 4; b++) begin
			px       = 1'(b >> 1);
			pz       = 1'(b);
			rr       = (IW+1)'(e1.gx) + (IW+1)'(px ^ e1.gx[0]);
			cc       = (IW+1)'(e1.gz) + (IW+1)'(pz ^ e1.gz[0]);
			raddr[b] = addr_of(rr, cc);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			bank_mem[wbank][waddr] <= e1.sample;
		end
		for (int b = 0; b < 4; b++) begin
			smp_s2[b] <= bank_mem[b][raddr[b]];
		end
	end

	// Corner samples: bank index is {row parity, column parity}.
	assign gx0 = e_s2.gx[0];
	assign gz0 = e_s2.gz[0];
	assign s00 = gx0 ? (gz0 ? smp_s2[3] : smp_s2[2]) : (gz0 ? smp_s2[1] : smp_s2[0]);
	assign s10 = gx0 ? (gz0 ? smp_s2[1] : smp_s2[0]) : (gz0 ? smp_s2[3] : smp_s2[2]);
	assign s01 = gx0 ? (gz0 ? smp_s2[2] : smp_s2[3]) : (gz0 ? smp_s2[0] : smp_s2[1]);
	assign s11 = gx0 ? (gz0 ? smp_s2[0] : smp_s2[1]) : (gz0 ? smp_s2[2] : smp_s2[3]);

	assign fx1  = FW'(e_s2.fx);
	assign fz1  = FW'(e_s2.fz);
	assign fsum = fx1 + fz1;

	always_comb begin
		if (fsum <= FW'(ONE)) begin
			wa = FW'(ONE) - fsum;
			sa = s00;
			wb = fx1;
			sb = s10;
			wc = fz1;
			sc = s01;
		end else begin
			wa = FW'(ONE) - fz1;
			sa = s10;
			wb = fsum - FW'(ONE);
			sb = s11;
			wc = FW'(ONE) - fx1;
			sc = s01;
		end
	end

	assign wsum = (FRAC_BITS+10)'(wa_s3 * sa_s3) + (FRAC_BITS+10)'(wb_s3 * sb_s3)
		+ (FRAC_BITS+10)'(wc_s3 * sc_s3);

	assign prod = w_s4 * cfg.height_scale;

	// Division by 255 as a sum of shifts; it lands at most one below the true quotient.
	assign vq   = p_s5[FRAC_BITS+38:FRAC_BITS];
	assign ssum = 40'(vq) + 40'(vq >> 8) + 40'(vq >> 16) + 40'(vq >> 24) + 40'(vq >> 32);
	assign rem  = 40'(vq_s6) - ({q0_s6, 8'd0} - 40'(q0_s6));

	assign hw   = $signed({3'b000, q_s7}) + 35'(cfg.height_offset);
	assign hsat = (hw[34:31] == 4'b0000 || hw[34:31] == 4'b1111) ? hw[31:0]
		: (hw[34] ? 32'sh8000_0000 : 32'sh7fff_ffff);
	assign lift = y_s7 < hsat;

	always_comb begin
		if (o_s7) begin
			rnext.new_y   = y_s7;
			rnext.outside = 1'b1;
			rnext.lifted  = 1'b0;
		end else begin
			rnext.new_y   = lift ? hsat : y_s7;
			rnext.outside = 1'b0;
			rnext.lifted  = lift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			rv_s8 <= 1'b0;
		end else begin
			v_s2  <= in_valid & (e1.kind == KIND_QUERY);
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			rv_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		e_s2   <= e1;
		wa_s3  <= wa;
		wb_s3  <= wb;
		wc_s3  <= wc;
		sa_s3  <= sa;
		sb_s3  <= sb;
		sc_s3  <= sc;
		y_s3   <= e_s2.y;
		o_s3   <= e_s2.outside;
		w_s4   <= wsum[FRAC_BITS+7:0];
		y_s4   <= y_s3;
		o_s4   <= o_s3;
		p_s5   <= prod;
		y_s5   <= y_s4;
		o_s5   <= o_s4;
		vq_s6  <= vq;
		q0_s6  <= ssum[39:8];
		y_s6   <= y_s5;
		o_s6   <= o_s5;
		q_s7   <= q0_s6 + 32'(rem >= 40'd255);
		y_s7   <= y_s6;
		o_s7   <= o_s6;
		res_s8 <= rnext;
	end

	assign res_valid = rv_s8;
	assign res       = res_s8;

endmodule

/* sv/hmtq_outq.sv */
`timescale 1ns / 1ps
// Result FIFO in front of the output port, built from registers.
// Depends on hmtq_pkg for the result word type.
module hmtq_outq #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hmtq_pkg::res_t din,
	input  logic           pop,
	output logic           empty,
	output hmtq_pkg::res_t dout
);
	import hmtq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	res_t          fifo_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (32'(rp_q) == DEPTH - 1) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	assign empty = (cnt_q == '0);
	assign dout  = fifo_q[rp_q];

endmodule

/* sv/heightmap_triangle_height_query_top.sv */
`timescale 1ns / 1ps
// Top level of the heightmap height query block: ports, registers and credit control.
// Depends on hmtq_pkg, hmtq_front, hmtq_queue, hmtq_back and hmtq_outq.
//
// Usage. Words enter through a queue-like port: a word is taken at a rising
// edge where push is high and full is low. kind 0 loads one sample into the
// height store, kind 1 asks for the ground-clamped y at (pos_x, pos_z).
// Results leave through a second queue-like port: while empty is low the
// oldest result is on new_y/outside/lifted, and pop at such an edge takes it.
// Loads give no result. Registers are written through wr_en/wr_index/wr_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Throughput: one word per cycle while full is low. The front runs two
// restoring dividers that each yield one quotient bit per stage. Height
// samples sit in four parity banks, so the four corners of a cell are read
// in the same cycle.
// Back pressure: when pop stays low, the result FIFO fills, the back stops
// taking words from the middle queue, and once that queue's credits run out
// full rises. No word is dropped. Reset clears all control state and presets
// the registers; the height store keeps no reset value and needs no clearing pass.
module heightmap_triangle_height_query_top #(
	parameter int MAP_DIM   = hmtq_pkg::MAP_DIM_DEF,
	parameter int FRAC_BITS = hmtq_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               kind,
	input  logic [7:0]         row,
	input  logic [7:0]         col,
	input  logic [7:0]         sample,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] new_y,
	output logic               outside,
	output logic               lifted,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);
	import hmtq_pkg::*;

	localparam int EW  = entry_bits(MAP_DIM, FRAC_BITS);
	// The middle queue must cover every word in flight in the front.
	localparam int QD  = 1 << $clog2(31 + FRAC_BITS + 4);
	localparam int FCW = $clog2(QD + 1);
	localparam int BCW = $clog2(OUT_DEPTH + 1);
	// Reset value of the two fixed-point registers: 1.0 at the configured width.
	localparam longint ONE_FX_RESET = longint'(1) << FRAC_BITS;

	cfg_t           cfg_q;
	logic           accept;
	logic           issue;
	logic           out_pop;
	logic [FCW-1:0] fcnt_q;
	logic [BCW-1:0] bcnt_q;

	logic           f_valid;
	logic [EW-1:0]  f_entry;
	logic           q_nonempty;
	logic           q_rvalid;
	logic [EW-1:0]  q_rdata;
	logic           load_done;
	logic           r_valid;
	res_t           r_word;
	res_t           o_word;

	// Configuration registers, written in place.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size     <= 31'(ONE_FX_RESET);
			cfg_q.height_scale  <= 31'(ONE_FX_RESET);
			cfg_q.height_offset <= '0;
			cfg_q.map_size      <= 9'd256;
		end else if (wr_en) begin
			case (wr_index)
				REG_CELL_SIZE:     cfg_q.cell_size     <= wr_data[30:0];
				REG_HEIGHT_SCALE:  cfg_q.height_scale  <= wr_data[30:0];
				REG_HEIGHT_OFFSET: cfg_q.height_offset <= wr_data;
				REG_MAP_SIZE:      cfg_q.map_size      <= wr_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Front credits: words accepted and not yet moved from the middle queue into the back.
	// Back credits: words moved into the back and not yet gone from the result FIFO.
	assign accept  = push & ~full;
	assign full    = (fcnt_q == FCW'(QD));
	assign issue   = q_nonempty & (bcnt_q < BCW'(OUT_DEPTH));
	assign out_pop = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt_q <= '0;
			bcnt_q <= '0;
		end else begin
			fcnt_q <= fcnt_q + FCW'(accept) - FCW'(issue);
			bcnt_q <= bcnt_q + BCW'(issue) - BCW'(load_done) - BCW'(out_pop);
		end
	end

	hmtq_front #(
		.MAP_DIM   (MAP_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.kind      (kind),
		.row       (row),
		.col       (col),
		.sample    (sample),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.cfg       (cfg_q),
		.out_valid (f_valid),
		.out_entry (f_entry)
	);

	hmtq_queue #(
		.W     (EW),
		.DEPTH (QD)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.wdata    (f_entry),
		.pop      (issue),
		.nonempty (q_nonempty),
		.rvalid   (q_rvalid),
		.rdata    (q_rdata)
	);

	hmtq_back #(
		.MAP_DIM   (MAP_DIM),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_rvalid),
		.in_entry  (q_rdata),
		.cfg       (cfg_q),
		.load_done (load_done),
		.res_valid (r_valid),
		.res       (r_word)
	);

	hmtq_outq #(
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (r_valid),
		.din    (r_word),
		.pop    (out_pop),
		.empty  (empty),
		.dout   (o_word)
	);

	assign new_y   = o_word.new_y;
	assign outside = o_word.outside;
	assign lifted  = o_word.lifted;

endmodule
